// ----- design/ted_pkg.sv -----
package ted_pkg;

    // result action codes
    typedef enum logic [4:0] {
        ACT_NONE        = 5'd0,
        ACT_DISPLAY     = 5'd1,
        ACT_UP          = 5'd2,
        ACT_DOWN        = 5'd3,
        ACT_RIGHT       = 5'd4,
        ACT_LEFT        = 5'd5,
        ACT_ERASE_HOME  = 5'd6,
        ACT_MOVE        = 5'd7,
        ACT_HOME        = 5'd8,
        ACT_ERASE_EOS   = 5'd9,
        ACT_ERASE_EOL   = 5'd10,
        ACT_INSLINE     = 5'd11,
        ACT_DELLINE     = 5'd12,
        ACT_CURSOR      = 5'd13,
        ACT_NORMAL      = 5'd14,
        ACT_START_ATTR  = 5'd15,
        ACT_START_BLINK = 5'd16,
        ACT_BACKSPACE   = 5'd17,
        ACT_TRANSMIT    = 5'd18
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] glyph;
        logic [4:0]  row;
        logic [6:0]  column;
        logic        attr_set;
        logic [4:0]  attributes;
        logic [7:0]  tx_byte;
        logic        last;
    } res_t;

    // control bytes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_ESC = 8'h1B;

    // escape letters that open a sequence or switch mode, and the normal-attribute letter
    localparam logic [7:0] ESC_MOVE    = 8'h46; // 'F'
    localparam logic [7:0] ESC_ATTR    = 8'h64; // 'd'
    localparam logic [7:0] ESC_GFX_ON  = 8'h52; // 'R'
    localparam logic [7:0] ESC_GFX_OFF = 8'h53; // 'S'
    localparam logic [7:0] ATTR_NORMAL = 8'h40; // '@'

    localparam logic [7:0] POS_OFFSET = 8'h1F;
    localparam logic [7:0] GFX_FIRST  = 8'h40;
    localparam logic [7:0] GFX_LAST   = 8'h6B;

    localparam int ENQ_LEN   = 6;
    localparam int ENQ_IDX_W = $clog2(ENQ_LEN);

    function automatic logic [15:0] box_glyph(input logic [3:0] idx);
        logic [15:0] g;
        case (idx)
            4'd0:    g = 16'h250F;
            4'd1:    g = 16'h2513;
            4'd2:    g = 16'h2517;
            4'd3:    g = 16'h251B;
            4'd4:    g = 16'h2533;
            4'd5:    g = 16'h252B;
            4'd6:    g = 16'h2523;
            4'd7:    g = 16'h253B;
            4'd8:    g = 16'h2501;
            4'd9:    g = 16'h2503;
            4'd10:   g = 16'h254B;
            default: g = 16'h0000;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] enq_reply(input logic [ENQ_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h02;
            3'd1:    b = 8'h02;
            3'd2:    b = 8'h33;
            3'd3:    b = 8'h31;
            3'd4:    b = 8'h30;
            3'd5:    b = 8'h32;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic action_t esc_action(input logic [7:0] c);
        action_t a;
        case (c)
            8'h41:   a = ACT_UP;          // 'A'
            8'h42:   a = ACT_DOWN;        // 'B'
            8'h43:   a = ACT_RIGHT;       // 'C'
            8'h44:   a = ACT_LEFT;        // 'D'
            8'h45:   a = ACT_ERASE_HOME;  // 'E'
            8'h48:   a = ACT_HOME;        // 'H'
            8'h4A:   a = ACT_ERASE_EOS;   // 'J'
            8'h4B:   a = ACT_ERASE_EOL;   // 'K'
            8'h4C:   a = ACT_INSLINE;     // 'L'
            8'h4D:   a = ACT_DELLINE;     // 'M'
            8'h5A:   a = ACT_CURSOR;      // 'Z'
            8'h65:   a = ACT_NORMAL;      // 'e'
            8'h6C:   a = ACT_START_BLINK; // 'l'
            8'h6D:   a = ACT_NORMAL;      // 'm'
            default: a = ACT_NONE;
        endcase
        return a;
    endfunction

    // {known, attribute bits}
    function automatic logic [5:0] attr_letter(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            8'h41:   r = 6'h21; // 'A'
            8'h42:   r = 6'h22;
            8'h43:   r = 6'h23;
            8'h50:   r = 6'h24; // 'P'
            8'h51:   r = 6'h25;
            8'h52:   r = 6'h26;
            8'h53:   r = 6'h27;
            8'h60:   r = 6'h28; // '`'
            8'h61:   r = 6'h29;
            8'h62:   r = 6'h2A;
            8'h63:   r = 6'h2B;
            8'h70:   r = 6'h2C; // 'p'
            8'h71:   r = 6'h2D;
            8'h72:   r = 6'h2E;
            8'h73:   r = 6'h2F;
            8'h24:   r = 6'h30; // '$'
            8'h34:   r = 6'h34; // '4'
            8'h35:   r = 6'h35;
            8'h36:   r = 6'h36;
            8'h37:   r = 6'h37;
            default: r = 6'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- design/terminal_escape_decoder.sv -----
// decodes a stream of received terminal bytes, one item per byte, into display
// commands for a vt52-style screen. every byte gives one result item except ENQ,
// which gives six transmit items carrying the identification reply, the sixth
// marked last. the block is an input register, one level of decode logic and an
// output register: a byte can be taken every cycle while no ENQ reply drains
// and the output is not stalled; each byte passes the input register and then
// the output register. during an ENQ reply the input register holds the ENQ until
// its last item is emitted. m_ready low stalls the output register and, once the
// input register is also full, s_ready drops
module terminal_escape_decoder #(
    parameter int SCREEN_ROWS    = 24,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    // received byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_char,
    // display command channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_action,
    output logic [15:0] m_glyph,
    output logic [4:0]  m_row,
    output logic [6:0]  m_column,
    output logic        m_attr_set,
    output logic [4:0]  m_attributes,
    output logic [7:0]  m_tx_byte,
    output logic        m_last
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;

    // reply position while an ENQ item drains
    logic [ted_pkg::ENQ_IDX_W-1:0] enq_idx_reg, enq_idx_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    ted_pkg::res_t out_res_reg;

    ted_pkg::res_t dec_res;
    logic          out_load;   // output register can take a new item
    logic          emit;       // a decoded item goes into the output register
    logic          consume;    // the held byte is finished with

    assign out_load = !out_valid_reg || m_ready;
    assign emit     = in_valid_reg && out_load;
    // only the last result of a byte frees the input register
    assign consume  = emit && dec_res.last;
    assign s_ready  = !in_valid_reg || consume;

    ted_decode #(
        .SCREEN_ROWS   (SCREEN_ROWS),
        .SCREEN_COLUMNS(SCREEN_COLUMNS)
    ) u_decode (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ch     (in_char_reg),
        .enq_idx(enq_idx_reg),
        .consume(consume),
        .res    (dec_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end

        enq_idx_next = enq_idx_reg;
        if (emit) begin
            enq_idx_next = dec_res.last ? '0 : enq_idx_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            enq_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            enq_idx_reg   <= enq_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_rx_char;
        end
        if (emit) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_action     = out_res_reg.action;
    assign m_glyph      = out_res_reg.glyph;
    assign m_row        = out_res_reg.row;
    assign m_column     = out_res_reg.column;
    assign m_attr_set   = out_res_reg.attr_set;
    assign m_attributes = out_res_reg.attributes;
    assign m_tx_byte    = out_res_reg.tx_byte;
    assign m_last       = out_res_reg.last;

    // reply counter stays inside the reply
    a_enq_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        enq_idx_reg <= ted_pkg::ENQ_IDX_W'(ted_pkg::ENQ_LEN - 1))
        else $error("reply index out of range");

    // a reply in progress keeps its ENQ byte held
    a_enq_held: assert property (@(posedge aclk) disable iff (!aresetn)
        enq_idx_reg != '0 |-> in_valid_reg)
        else $error("reply in progress without held byte");

    // a non-final transmit item is followed by the next item of the reply
    a_reply_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("reply cut short");

    // position only on a move
    a_pos_only_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action != ted_pkg::ACT_MOVE |-> m_row == '0 && m_column == '0)
        else $error("position on a non-move item");

    // attribute bits only when started
    a_attr_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_attr_set |-> m_attributes == '0)
        else $error("attribute bits without attr_set");

endmodule

// ----- design/ted_decode.sv -----
module ted_decode #(
    parameter int SCREEN_ROWS    = 24,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [7:0]                   ch,
    input  logic [ted_pkg::ENQ_IDX_W-1:0] enq_idx,
    input  logic                         consume,
    output ted_pkg::res_t                res
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_ROW  = 3'd2,
        PH_COL  = 3'd3,
        PH_ATTR = 3'd4
    } phase_t;

    localparam logic [8:0] ROW_LIMIT = 9'(SCREEN_ROWS + 31);
    localparam logic [8:0] COL_LIMIT = 9'(SCREEN_COLUMNS + 31);

    phase_t     phase_reg, phase_next;
    logic [7:0] saved_row_reg, saved_row_next;
    logic       gfx_reg, gfx_next;

    logic [8:0] row_val;
    logic [8:0] col_val;
    logic       pos_ok;
    logic [5:0] attr_lut;

    always_comb begin
        if ({1'b0, saved_row_reg} > ROW_LIMIT) begin
            row_val = 9'(SCREEN_ROWS);
        end else begin
            row_val = {1'b0, saved_row_reg} - {1'b0, ted_pkg::POS_OFFSET};
        end
        col_val  = {1'b0, ch} - {1'b0, ted_pkg::POS_OFFSET};
        pos_ok   = (saved_row_reg > ted_pkg::POS_OFFSET) && (ch > ted_pkg::POS_OFFSET)
                   && ({1'b0, ch} <= COL_LIMIT);
        attr_lut = ted_pkg::attr_letter(ch);
    end

    always_comb begin
        res            = '0;
        res.action     = ted_pkg::ACT_NONE;
        res.last       = 1'b1;
        phase_next     = PH_IDLE;
        saved_row_next = saved_row_reg;
        gfx_next       = gfx_reg;
        unique case (phase_reg)
            PH_ESC: begin
                if (ch == ted_pkg::ESC_MOVE) begin
                    phase_next = PH_ROW;
                end else if (ch == ted_pkg::ESC_ATTR) begin
                    phase_next = PH_ATTR;
                end else if (ch == ted_pkg::ESC_GFX_ON) begin
                    gfx_next = 1'b1;
                end else if (ch == ted_pkg::ESC_GFX_OFF) begin
                    gfx_next = 1'b0;
                end else begin
                    res.action = ted_pkg::esc_action(ch);
                end
            end
            PH_ROW: begin
                saved_row_next = ch;
                phase_next     = PH_COL;
            end
            PH_COL: begin
                if (pos_ok) begin
                    res.action = ted_pkg::ACT_MOVE;
                    res.row    = row_val[4:0];
                    res.column = col_val[6:0];
                end
            end
            PH_ATTR: begin
                if (ch == ted_pkg::ATTR_NORMAL) begin
                    res.action = ted_pkg::ACT_NORMAL;
                end else if (attr_lut[5]) begin
                    res.action     = ted_pkg::ACT_START_ATTR;
                    res.attr_set   = 1'b1;
                    res.attributes = attr_lut[4:0];
                end
            end
            default: begin
                // idle, and the unused phase codes
                if (ch == ted_pkg::CH_ESC) begin
                    phase_next = PH_ESC;
                end else if (ch == ted_pkg::CH_BS) begin
                    res.action = ted_pkg::ACT_BACKSPACE;
                end else if (ch == ted_pkg::CH_ENQ) begin
                    res.action  = ted_pkg::ACT_TRANSMIT;
                    res.tx_byte = ted_pkg::enq_reply(enq_idx);
                    res.last    = (enq_idx == ted_pkg::ENQ_IDX_W'(ted_pkg::ENQ_LEN - 1));
                end else if (ch == ted_pkg::CH_NUL) begin
                    res.action = ted_pkg::ACT_NONE;
                end else if (gfx_reg && ch >= ted_pkg::GFX_FIRST
                             && ch <= ted_pkg::GFX_LAST) begin
                    res.action     = ted_pkg::ACT_DISPLAY;
                    res.glyph      = ted_pkg::box_glyph(ch[5:2]);
                    res.attr_set   = |ch[1:0];
                    res.attributes = {3'b000, ch[1:0]};
                end else begin
                    res.action = ted_pkg::ACT_DISPLAY;
                    res.glyph  = {8'h00, ch};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            saved_row_reg <= 8'h00;
            gfx_reg       <= 1'b0;
        end else if (consume) begin
            phase_reg     <= phase_next;
            saved_row_reg <= saved_row_next;
            gfx_reg       <= gfx_next;
        end
    end

endmodule
